// ===== rtl/fdl_pkg.sv =====
// Package for the feedback delay line with low-pass: sizes, fixed-point constants,
// register map, controller states and the command and status structs.
// Used by every module of the block; depends on nothing.
package fdl_pkg;

	localparam int MAX_DELAY  = 131072;
	localparam int CHANNELS   = 2;
	localparam int STORE_SIZE = MAX_DELAY * CHANNELS;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int BACK_W     = $clog2(STORE_SIZE + 1);
	localparam int DLY_W      = $clog2(MAX_DELAY + 1) > 18 ? $clog2(MAX_DELAY + 1) : 18;
	localparam int CH_W       = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

	localparam int ONE_Q20   = 1048576;
	localparam int KEEP_Q20  = 1047527;
	localparam int TAKE_Q20  = 1049;
	localparam int TAKE_MAG  = 32 * TAKE_Q20;
	localparam int LIMIT_Q20 = 419430;
	localparam int FLOOR_Q20 = 104858;
	localparam int FB_CLIP   = 29491;
	localparam int RECOVER_BIAS = ONE_Q20 * TAKE_Q20 + ONE_Q20 - 1;

	localparam int QUOT_W = 21;
	localparam logic [40:0] DIV_NUM = 41'(LIMIT_Q20) << 20;

	localparam int ACC_W = 48;

	localparam logic [2:0] REG_DELAY   = 3'd0;
	localparam logic [2:0] REG_FB_GAIN = 3'd1;
	localparam logic [2:0] REG_DRY     = 3'd2;
	localparam logic [2:0] REG_WET     = 3'd3;
	localparam logic [2:0] REG_FILT_EN = 3'd4;
	localparam logic [2:0] REG_FF      = 3'd5;
	localparam logic [2:0] REG_FB_ONE  = 3'd6;
	localparam logic [2:0] REG_FB_TWO  = 3'd7;

	typedef struct packed {
		logic [17:0]        delay_samples;
		logic [14:0]        feedback_gain;
		logic [15:0]        dry_gain;
		logic [15:0]        wet_gain;
		logic               filter_enable;
		logic [16:0]        ff_coef;
		logic signed [17:0] fb_coef_one;
		logic signed [17:0] fb_coef_two;
	} cfg_t;

	typedef enum logic [3:0] {
		SEL_FFX, SEL_B1Y1, SEL_B2Y2, SEL_EK, SEL_EM, SEL_RK, SEL_XD, SEL_DW, SEL_GR, SEL_DA
	} sel_t;

	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD, ST_LD,
		ST_F1, ST_F2, ST_F3, ST_F4, ST_F5,
		ST_E1, ST_E2, ST_E3, ST_E4, ST_DV,
		ST_R1, ST_R2, ST_R3,
		ST_M1, ST_M2, ST_M3, ST_M4,
		ST_A1, ST_A2, ST_A3, ST_A4
	} state_t;

	typedef struct packed {
		sel_t    sel;
		acc_op_t op;
		logic    cap_x;
		logic    mem_rd;
		logic    load_d;
		logic    filt_done;
		logic    energy_done;
		logic    div_start;
		logic    r_div;
		logic    r_rec;
		logic    mix_cap;
		logic    amt_cap;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic over;
		logic div_done;
		logic out_busy;
	} status_t;

endpackage

// ===== rtl/fdl_regs.sv =====
// Configuration registers of the feedback delay line behind an APB-style port.
// Depends on fdl_pkg for the register map and the configuration struct.
module fdl_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output fdl_pkg::cfg_t cfg
);
	import fdl_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_samples <= 18'd22050;
			cfg_q.feedback_gain <= '0;
			cfg_q.dry_gain      <= 16'd32768;
			cfg_q.wet_gain      <= 16'd9830;
			cfg_q.filter_enable <= 1'b0;
			cfg_q.ff_coef       <= '0;
			cfg_q.fb_coef_one   <= '0;
			cfg_q.fb_coef_two   <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_DELAY:   cfg_q.delay_samples <= pwdata[17:0];
				REG_FB_GAIN: cfg_q.feedback_gain <= pwdata[14:0];
				REG_DRY:     cfg_q.dry_gain      <= pwdata[15:0];
				REG_WET:     cfg_q.wet_gain      <= pwdata[15:0];
				REG_FILT_EN: cfg_q.filter_enable <= pwdata[0];
				REG_FF:      cfg_q.ff_coef       <= pwdata[16:0];
				REG_FB_ONE:  cfg_q.fb_coef_one   <= pwdata[17:0];
				REG_FB_TWO:  cfg_q.fb_coef_two   <= pwdata[17:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_DELAY:   prdata = {14'd0, cfg_q.delay_samples};
			REG_FB_GAIN: prdata = {17'd0, cfg_q.feedback_gain};
			REG_DRY:     prdata = {16'd0, cfg_q.dry_gain};
			REG_WET:     prdata = {16'd0, cfg_q.wet_gain};
			REG_FILT_EN: prdata = {31'd0, cfg_q.filter_enable};
			REG_FF:      prdata = {15'd0, cfg_q.ff_coef};
			REG_FB_ONE:  prdata = {{14{cfg_q.fb_coef_one[17]}}, cfg_q.fb_coef_one};
			REG_FB_TWO:  prdata = {{14{cfg_q.fb_coef_two[17]}}, cfg_q.fb_coef_two};
		endcase
	end

endmodule

// ===== rtl/fdl_div.sv =====
// Bit-serial restoring divider for the feedback reduction: constant numerator
// over the tracked energy, one quotient bit per cycle. Depends on fdl_pkg.
module fdl_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [19:0]               divisor,
	output logic                      done,
	output logic [fdl_pkg::QUOT_W-1:0] quotient
);
	import fdl_pkg::*;

	logic                      busy_q;
	logic                      done_q;
	logic [$clog2(QUOT_W)-1:0] cnt_q;
	logic [19:0]               den_q;
	logic [19:0]               rem_q;
	logic [QUOT_W-1:0]         num_q;
	logic [QUOT_W-1:0]         quo_q;
	logic [20:0]               trial;
	logic [20:0]               diff;

	assign trial = {rem_q, num_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == ($clog2(QUOT_W))'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= DIV_NUM[QUOT_W+19:QUOT_W];
			num_q <= DIV_NUM[QUOT_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[QUOT_W-2:0], 1'b0};
			if (!diff[20]) begin
				rem_q <= diff[19:0];
				quo_q <= {quo_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[19:0];
				quo_q <= {quo_q[QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/fdl_ctrl.sv =====
// Controller of the feedback delay line: steps the datapath through the
// read, optional filter, energy, reduction, mix and write phases. Depends on fdl_pkg.
module fdl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             filter_enable,
	input  fdl_pkg::status_t status,
	output fdl_pkg::cmd_t    cmd
);
	import fdl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_FFX;
		cmd.op   = ACC_HOLD;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_x = 1'b1;
					state_d   = ST_RD;
				end
			end
			ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_LD;
			end
			ST_LD: begin
				cmd.load_d = 1'b1;
				state_d    = filter_enable ? ST_F1 : ST_E1;
			end
			ST_F1: begin
				cmd.sel = SEL_FFX;
				state_d = ST_F2;
			end
			ST_F2: begin
				cmd.sel = SEL_B1Y1;
				cmd.op  = ACC_LOAD;
				state_d = ST_F3;
			end
			ST_F3: begin
				cmd.sel = SEL_B2Y2;
				cmd.op  = ACC_SUB;
				state_d = ST_F4;
			end
			ST_F4: begin
				cmd.op  = ACC_SUB;
				state_d = ST_F5;
			end
			ST_F5: begin
				cmd.filt_done = 1'b1;
				state_d       = ST_E1;
			end
			ST_E1: begin
				cmd.sel = SEL_EK;
				state_d = ST_E2;
			end
			ST_E2: begin
				cmd.sel = SEL_EM;
				cmd.op  = ACC_LOAD;
				state_d = ST_E3;
			end
			ST_E3: begin
				cmd.op  = ACC_ADD;
				state_d = ST_E4;
			end
			ST_E4: begin
				cmd.energy_done = 1'b1;
				if (status.over) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DV;
				end else begin
					state_d = ST_R1;
				end
			end
			ST_DV: begin
				if (status.div_done) begin
					cmd.r_div = 1'b1;
					state_d   = ST_M1;
				end
			end
			ST_R1: begin
				cmd.sel = SEL_RK;
				state_d = ST_R2;
			end
			ST_R2: begin
				cmd.op  = ACC_LOAD;
				state_d = ST_R3;
			end
			ST_R3: begin
				cmd.r_rec = 1'b1;
				state_d   = ST_M1;
			end
			ST_M1: begin
				cmd.sel = SEL_XD;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.sel = SEL_DW;
				cmd.op  = ACC_LOAD;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.sel = SEL_GR;
				cmd.op  = ACC_ADD;
				state_d = ST_M4;
			end
			ST_M4: begin
				cmd.mix_cap = 1'b1;
				cmd.op      = ACC_LOAD;
				state_d     = ST_A1;
			end
			ST_A1: begin
				cmd.amt_cap = 1'b1;
				state_d     = ST_A2;
			end
			ST_A2: begin
				cmd.sel = SEL_DA;
				state_d = ST_A3;
			end
			ST_A3: begin
				cmd.op  = ACC_LOAD;
				state_d = ST_A4;
			end
			ST_A4: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/fdl_dp.sv =====
// Datapath of the feedback delay line: delay store, filter histories, shared
// multiplier and accumulator, energy and reduction state, output register.
// Depends on fdl_pkg and instantiates fdl_div.
module fdl_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  fdl_pkg::cfg_t      cfg,
	input  fdl_pkg::cmd_t      cmd,
	output fdl_pkg::status_t   status,
	input  logic signed [15:0] in_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_sample,
	output logic               limiting_active
);
	import fdl_pkg::*;

	logic signed [15:0] mem [STORE_SIZE];

	logic [ADDR_W-1:0]  wp_q;
	logic [CH_W-1:0]    ch_q;
	logic               filled_q;
	logic signed [15:0] x_q;
	logic signed [15:0] rd_s1;
	logic               ok_s1;
	logic signed [15:0] delayed_q;
	logic signed [23:0] d_q;
	logic [19:0]        e_q;
	logic [20:0]        r_q;
	logic               lim_q;
	logic signed [15:0] mix_q;
	logic [15:0]        amount_q;
	logic signed [ACC_W-1:0] p_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic               out_lim_q;

	logic signed [15:0] xh1_q [CHANNELS];
	logic signed [15:0] xh2_q [CHANNELS];
	logic signed [23:0] yh1_q [CHANNELS];
	logic signed [23:0] yh2_q [CHANNELS];

	logic [DLY_W-1:0]   dly;
	logic [BACK_W-1:0]  back;
	logic [BACK_W:0]    rp_diff;
	logic [ADDR_W-1:0]  rp;
	logic               rd_ok;
	logic signed [17:0] xs;
	logic [23:0]        mag;
	logic signed [24:0] opa;
	logic signed [24:0] opb;
	logic signed [49:0] prod;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ACC_W-1:0] y_sh;
	logic signed [23:0] y_new;
	logic signed [ACC_W-1:0] e_sh;
	logic [19:0]        e_new;
	logic signed [ACC_W-1:0] r_sh;
	logic [20:0]        r_rec;
	logic [20:0]        r_div;
	logic               div_done;
	logic [QUOT_W-1:0]  quo;
	logic signed [ACC_W-1:0] q15_sh;
	logic signed [15:0] mix_new;
	logic signed [15:0] fbs;
	logic signed [16:0] wr_sum;
	logic signed [15:0] wr_val;

	always_comb begin
		if ({{(DLY_W-18){1'b0}}, cfg.delay_samples} > DLY_W'(MAX_DELAY)) begin
			dly = DLY_W'(MAX_DELAY);
		end else begin
			dly = {{(DLY_W-18){1'b0}}, cfg.delay_samples};
		end
		back    = BACK_W'(dly) * BACK_W'(CHANNELS);
		rp_diff = {1'b0, BACK_W'(wp_q)} - {1'b0, back};
		if (rp_diff[BACK_W]) begin
			rp = ADDR_W'(rp_diff + (BACK_W+1)'(STORE_SIZE));
		end else begin
			rp = rp_diff[ADDR_W-1:0];
		end
		rd_ok = (dly != '0) && (filled_q || (rp < wp_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_s1 <= mem[rp];
		end
		if (cmd.finish && !status.out_busy) begin
			mem[wp_q] <= wr_val;
		end
	end

	assign xs  = 18'(delayed_q) + (18'(xh1_q[ch_q]) <<< 1) + 18'(xh2_q[ch_q]);
	assign mag = d_q[23] ? 24'(-d_q) : 24'(d_q);

	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.sel)
			SEL_FFX: begin
				opa = {8'd0, cfg.ff_coef};
				opb = {{7{xs[17]}}, xs};
			end
			SEL_B1Y1: begin
				opa = {{7{cfg.fb_coef_one[17]}}, cfg.fb_coef_one};
				opb = {yh1_q[ch_q][23], yh1_q[ch_q]};
			end
			SEL_B2Y2: begin
				opa = {{7{cfg.fb_coef_two[17]}}, cfg.fb_coef_two};
				opb = {yh2_q[ch_q][23], yh2_q[ch_q]};
			end
			SEL_EK: begin
				opa = {5'd0, e_q};
				opb = 25'(KEEP_Q20);
			end
			SEL_EM: begin
				opa = {1'b0, mag};
				opb = 25'(TAKE_MAG);
			end
			SEL_RK: begin
				opa = {4'd0, r_q};
				opb = 25'(KEEP_Q20);
			end
			SEL_XD: begin
				opa = {{9{x_q[15]}}, x_q};
				opb = {9'd0, cfg.dry_gain};
			end
			SEL_DW: begin
				opa = {d_q[23], d_q};
				opb = {9'd0, cfg.wet_gain};
			end
			SEL_GR: begin
				opa = {10'd0, cfg.feedback_gain};
				opb = {4'd0, r_q};
			end
			SEL_DA: begin
				opa = {d_q[23], d_q};
				opb = {9'd0, amount_q};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod = opa * opb;

	always_ff @(posedge clk) begin
		p_s1 <= prod[ACC_W-1:0];
		case (cmd.op)
			ACC_LOAD: acc_q <= p_s1;
			ACC_ADD:  acc_q <= acc_q + p_s1;
			ACC_SUB:  acc_q <= acc_q - p_s1;
			default:  acc_q <= acc_q;
		endcase
	end

	always_comb begin
		acc_rnd = acc_q + ACC_W'(32768);
		y_sh    = acc_rnd >>> 16;
		if (y_sh > ACC_W'(8388607)) begin
			y_new = 24'sd8388607;
		end else if (y_sh < -ACC_W'(8388608)) begin
			y_new = -24'sd8388608;
		end else begin
			y_new = y_sh[23:0];
		end

		e_sh = acc_q >>> 20;
		if (e_sh > ACC_W'(ONE_Q20 - 1)) begin
			e_new = 20'(ONE_Q20 - 1);
		end else begin
			e_new = e_sh[19:0];
		end

		r_sh = (acc_q + ACC_W'(RECOVER_BIAS)) >>> 20;
		if (r_sh > ACC_W'(ONE_Q20)) begin
			r_rec = 21'(ONE_Q20);
		end else begin
			r_rec = r_sh[20:0];
		end

		if (quo < QUOT_W'(FLOOR_Q20)) begin
			r_div = 21'(FLOOR_Q20);
		end else begin
			r_div = 21'(quo);
		end

		q15_sh = (acc_q + ACC_W'(16384)) >>> 15;
		if (q15_sh > ACC_W'(32767)) begin
			mix_new = 16'sh7fff;
		end else if (q15_sh < -ACC_W'(32768)) begin
			mix_new = -16'sh8000;
		end else begin
			mix_new = q15_sh[15:0];
		end
		if (q15_sh > ACC_W'(FB_CLIP)) begin
			fbs = 16'(FB_CLIP);
		end else if (q15_sh < -ACC_W'(FB_CLIP)) begin
			fbs = -16'(FB_CLIP);
		end else begin
			fbs = q15_sh[15:0];
		end
		wr_sum = 17'(x_q) + 17'(fbs);
		if (wr_sum > 17'sd32767) begin
			wr_val = 16'sh7fff;
		end else if (wr_sum < -17'sd32768) begin
			wr_val = -16'sh8000;
		end else begin
			wr_val = wr_sum[15:0];
		end
	end

	fdl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (e_new),
		.done     (div_done),
		.quotient (quo)
	);

	assign status.over     = e_new > 20'(LIMIT_Q20);
	assign status.div_done = div_done;
	assign status.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.cap_x) begin
			x_q <= in_sample;
		end
		if (cmd.mem_rd) begin
			ok_s1 <= rd_ok;
		end
		if (cmd.load_d) begin
			delayed_q <= ok_s1 ? rd_s1 : 16'sd0;
			d_q       <= ok_s1 ? 24'(rd_s1) : 24'sd0;
		end else if (cmd.filt_done) begin
			d_q <= y_new;
		end
		if (cmd.mix_cap) begin
			mix_q <= mix_new;
		end
		if (cmd.amt_cap) begin
			amount_q <= acc_q[35:20] + 16'(acc_q[19]);
		end
		if (cmd.finish && !status.out_busy) begin
			out_sample_q <= mix_q;
			out_lim_q    <= lim_q;
		end
		if (cmd.energy_done) begin
			lim_q <= status.over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			ch_q        <= '0;
			filled_q    <= 1'b0;
			e_q         <= '0;
			r_q         <= 21'(ONE_Q20);
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				xh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh1_q[i] <= '0;
				yh2_q[i] <= '0;
			end
		end else begin
			if (cmd.filt_done) begin
				xh2_q[ch_q] <= xh1_q[ch_q];
				xh1_q[ch_q] <= delayed_q;
				yh2_q[ch_q] <= yh1_q[ch_q];
				yh1_q[ch_q] <= y_new;
			end
			if (cmd.energy_done) begin
				e_q <= e_new;
			end
			if (cmd.r_div) begin
				r_q <= r_div;
			end else if (cmd.r_rec) begin
				r_q <= r_rec;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish && !status.out_busy) begin
				out_valid_q <= 1'b1;
				if (wp_q == ADDR_W'(STORE_SIZE - 1)) begin
					wp_q     <= '0;
					filled_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
				if (ch_q == CH_W'(CHANNELS - 1)) begin
					ch_q <= '0;
				end else begin
					ch_q <= ch_q + 1'b1;
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_sample      = out_sample_q;
	assign limiting_active = out_lim_q;

	a_r_range: assert property (@(posedge clk) disable iff (!arst_n)
		(r_q >= 21'(FLOOR_Q20)) && (r_q <= 21'(ONE_Q20)))
		else $error("feedback reduction left its range");

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= CH_W'(CHANNELS - 1))
		else $error("channel index out of range");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && !status.out_busy |=> out_valid_q)
		else $error("finished transaction did not produce a result");

	a_amount: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.amt_cap |=> amount_q <= 16'd32768)
		else $error("feedback amount above one");

endmodule

// ===== rtl/feedback_delay_with_lowpass.sv =====
// Feedback delay line with an optional per-channel biquad low-pass on the delayed
// path and feedback energy protection. Takes one interleaved Q1.15 sample per
// transaction and returns one mixed sample. Each transaction runs through the shared
// multiply-accumulate sequence, with extra filter steps when the filter is enabled,
// and waits for the bit-serial reduction divider when the tracked energy exceeds 0.4.
// The delay store needs no clearing pass: entries not yet written read as zero.
// Depends on fdl_pkg, fdl_regs, fdl_ctrl, fdl_dp and fdl_div.
module feedback_delay_with_lowpass (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] in_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_sample,
	output logic               limiting_active
);
	import fdl_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	assign pready = 1'b1;

	fdl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	fdl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.filter_enable (cfg.filter_enable),
		.status        (status),
		.cmd           (cmd)
	);

	fdl_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.status          (status),
		.in_sample       (in_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_sample      (out_sample),
		.limiting_active (limiting_active)
	);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for feedback_delay_with_lowpass: drives samples over the
// valid/ready input, programs registers over APB and checks every output transaction
// against a built-in fixed-point predictor. Depends on fdl_pkg and the RTL only.
module tb;
	import fdl_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [15:0] smp;
		logic               lim;
	} mix_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] in_sample;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] out_sample;
	logic               limiting_active;

	logic signed [15:0] pending_samples[$];
	mix_result_t        expected_mix[$];
	int                 send_idle, recv_idle;
	int                 errors;
	longint             cycles;

	int                 m_delay, m_fb_gain, m_dry, m_wet, m_fen, m_ff, m_b1, m_b2;
	shortint            echo_store[STORE_SIZE];
	int                 wr_pos, chan;
	longint             x_hist1[CHANNELS], x_hist2[CHANNELS];
	longint             y_hist1[CHANNELS], y_hist2[CHANNELS];
	longint             energy, reduction;

	feedback_delay_with_lowpass dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic mix_step(input logic signed [15:0] smp, output mix_result_t res);
		longint x, delayed, d, acc, mag, e, r, amount, fbs, wr, mix;
		int     dly, rp;
		x = smp;
		delayed = 0;
		dly = m_delay > MAX_DELAY ? MAX_DELAY : m_delay;
		if (dly != 0) begin
			rp = (wr_pos + STORE_SIZE - dly * CHANNELS) % STORE_SIZE;
			delayed = echo_store[rp];
		end
		d = delayed;
		if (m_fen != 0) begin
			acc = longint'(m_ff) * (delayed + 2 * x_hist1[chan] + x_hist2[chan])
				- longint'(m_b1) * y_hist1[chan] - longint'(m_b2) * y_hist2[chan];
			d = clip(round_shift(acc, 16), -8388608, 8388607);
			x_hist2[chan] = x_hist1[chan];
			x_hist1[chan] = delayed;
			y_hist2[chan] = y_hist1[chan];
			y_hist1[chan] = d;
		end
		mag = d < 0 ? -d : d;
		e = (energy * KEEP_Q20 + mag * 32 * TAKE_Q20) >> 20;
		if (e > ONE_Q20 - 1)
			e = ONE_Q20 - 1;
		energy = e;
		if (energy > LIMIT_Q20) begin
			r = (longint'(LIMIT_Q20) << 20) / energy;
			if (r < FLOOR_Q20)
				r = FLOOR_Q20;
		end else begin
			r = (reduction * KEEP_Q20 + longint'(ONE_Q20) * TAKE_Q20 + ONE_Q20 - 1) >> 20;
			if (r > ONE_Q20)
				r = ONE_Q20;
		end
		reduction = r;
		mix = clip(round_shift(x * m_dry + d * m_wet, 15), -32768, 32767);
		amount = (longint'(m_fb_gain) * r + (1 << 19)) >> 20;
		fbs = clip(round_shift(d * amount, 15), -FB_CLIP, FB_CLIP);
		wr = clip(x + fbs, -32768, 32767);
		echo_store[wr_pos] = shortint'(wr);
		wr_pos = wr_pos + 1 >= STORE_SIZE ? 0 : wr_pos + 1;
		chan = chan + 1 >= CHANNELS ? 0 : chan + 1;
		res.smp = mix[15:0];
		res.lim = energy > LIMIT_Q20;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	// Driver: feeds pending samples and predicts each accepted transaction.
	always @(posedge clk) begin
		mix_result_t res;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				mix_step(in_sample, res);
				expected_mix.push_back(res);
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					in_sample <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	// Monitor: compares each output transaction with the oldest prediction.
	always @(posedge clk) begin
		mix_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_mix.size() == 0) begin
				report_mismatch("unexpected output", out_sample, 0);
			end else begin
				want = expected_mix.pop_front();
				if (out_sample !== want.smp)
					report_mismatch("out_sample", out_sample, want.smp);
				if (limiting_active !== want.lim)
					report_mismatch("limiting_active", limiting_active, want.lim);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DELAY:   m_delay = value & 32'h3FFFF;
			REG_FB_GAIN: m_fb_gain = value & 32'h7FFF;
			REG_DRY:     m_dry = value & 32'hFFFF;
			REG_WET:     m_wet = value & 32'hFFFF;
			REG_FILT_EN: m_fen = value & 1;
			REG_FF:      m_ff = value & 32'h1FFFF;
			REG_FB_ONE:  m_b1 = int'(signed'(18'(value)));
			REG_FB_TWO:  m_b2 = int'(signed'(18'(value)));
			default: ;
		endcase
	endtask

	task automatic write_all(input int dl, fb, dry, wet, fen, ff, b1, b2);
		reg_write(REG_DELAY, dl);
		reg_write(REG_FB_GAIN, fb);
		reg_write(REG_DRY, dry);
		reg_write(REG_WET, wet);
		reg_write(REG_FILT_EN, fen);
		reg_write(REG_FF, ff);
		reg_write(REG_FB_ONE, b1);
		reg_write(REG_FB_TWO, b2);
	endtask

	task automatic drain;
		while (pending_samples.size() > 0 || in_valid || expected_mix.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample(input int loud);
		case ($urandom_range(loud ? 5 : 3))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(4000)) - 2000);
			2: return $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
			default: return $urandom_range(1) ? 16'sh7000 + 16'($urandom_range(4095))
				: -16'sh7000 - 16'($urandom_range(4095));
		endcase
	endfunction

	initial begin
		int dl, loud;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_sample = '0;
		out_ready = 1'b0;
		errors = 0;
		cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		m_delay = 22050;
		m_fb_gain = 0;
		m_dry = 32768;
		m_wet = 9830;
		m_fen = 0;
		m_ff = 0;
		m_b1 = 0;
		m_b2 = 0;
		wr_pos = 0;
		chan = 0;
		energy = 0;
		reduction = ONE_Q20;
		for (int i = 0; i < CHANNELS; i++) begin
			x_hist1[i] = 0;
			x_hist2[i] = 0;
			y_hist1[i] = 0;
			y_hist2[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, then zero delay through the filter, then full-scale feedback, then maximum delay.
		pending_samples = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh5555};
		drain();
		write_all(0, 27853, 65535, 65535, 1, 1147, -104858, 43909);
		pending_samples = '{16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh2AAA, 16'sh0100};
		drain();
		write_all(1, 32767, 32768, 32768, 0, 65536, 131071, -65536);
		for (int i = 0; i < 10; i++)
			pending_samples.push_back(i[0] ? -16'sh8000 : 16'sh7FFF);
		drain();
		write_all(MAX_DELAY, 0, 0, 0, 1, 131071, -131072, 65536);
		pending_samples = '{16'sh1234, -16'sh1234};
		drain();

		for (int mode = 0; mode < 3; mode++) begin
			send_idle = mode == 0 ? 21 : (mode == 1 ? 84 : 0);
			recv_idle = mode == 0 ? 84 : (mode == 1 ? 21 : 0);
			for (int ph = 0; ph < 6; ph++) begin
				case ($urandom_range(7))
					0: dl = ph == 0 ? MAX_DELAY : 262143;
					1: dl = 0;
					default: dl = $urandom_range(12);
				endcase
				loud = $urandom_range(1);
				if ($urandom_range(1))
					write_all(dl, loud ? 27853 : $urandom_range(32767), $urandom_range(65535),
						$urandom_range(65535), $urandom_range(1), 1147, -104858, 43909);
				else
					write_all(dl, $urandom_range(32767), $urandom_range(65535),
						$urandom_range(65535), $urandom_range(1), $urandom_range(131071),
						$urandom_range(262143), $urandom_range(262143));
				for (int i = 0; i < 97; i++)
					pending_samples.push_back(pick_sample(loud));
				drain();
			end
		end

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
